// ===== rtl/spmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared types and constants of the strict priority multi-level queue.
// ----------------------------------------------------------------------------
package spmf_pkg;

   localparam int PRIO_W   = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_PRIO = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      status_type               status;
      logic                     any_waiting;
      logic [PRIO_W-1:0]        head_priority;
   } level_info_type;

endpackage

// ===== rtl/spmf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module spmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spmf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spmf_ctrl
// Per-level occupancy and pointers, top-level priority encoder and the
// store addresses for push and head read.
// ----------------------------------------------------------------------------
module spmf_ctrl #(
   parameter int NUM_LEVELS  = 8,
   parameter int LEVEL_DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       apply,
   input  logic                                       func,
   input  logic [spmf_pkg::PRIO_W-1:0]                priority_req,
   output logic                                       wr_en,
   output logic [$clog2(NUM_LEVELS*LEVEL_DEPTH)-1:0]  wr_addr,
   output logic [$clog2(NUM_LEVELS*LEVEL_DEPTH)-1:0]  rd_addr,
   output spmf_pkg::level_info_type                   info
);

   import spmf_pkg::*;

   localparam int LW = $clog2(NUM_LEVELS);
   localparam int PW = $clog2(LEVEL_DEPTH);
   localparam int CW = $clog2(LEVEL_DEPTH + 1);
   localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);

   logic [CW-1:0] count_ff  [NUM_LEVELS];
   logic [CW-1:0] count_in  [NUM_LEVELS];
   logic [PW-1:0] rd_ptr_ff [NUM_LEVELS];
   logic [PW-1:0] rd_ptr_in [NUM_LEVELS];
   logic [PW-1:0] wr_ptr_ff [NUM_LEVELS];
   logic [PW-1:0] wr_ptr_in [NUM_LEVELS];

   logic              any_waiting;
   logic [LW-1:0]     top_lv;
   logic              prio_valid;
   logic [PRIO_W-1:0] prio_m1;
   logic [LW-1:0]     push_lv;
   status_type        status;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] ptr);
      return (ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   always_comb begin
      any_waiting = 1'b0;
      top_lv      = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            any_waiting = 1'b1;
            top_lv      = LW'(i);
         end
      end
   end

   assign prio_valid = (priority_req != '0) && (priority_req <= PRIO_W'(NUM_LEVELS));
   assign prio_m1    = priority_req - PRIO_W'(1);
   assign push_lv    = prio_m1[LW-1:0];

   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      status    = STATUS_OK;
      wr_en     = 1'b0;
      if (apply) begin
         if (func == FUNC_PUSH) begin
            if (!prio_valid) begin
               status = STATUS_BAD_PRIO;
            end else if (count_ff[push_lv] == CW'(LEVEL_DEPTH)) begin
               status = STATUS_FULL;
            end else begin
               wr_en              = 1'b1;
               wr_ptr_in[push_lv] = bump(wr_ptr_ff[push_lv]);
               count_in[push_lv]  = count_ff[push_lv] + CW'(1);
            end
         end else begin
            if (!any_waiting) begin
               status = STATUS_EMPTY;
            end else begin
               rd_ptr_in[top_lv] = bump(rd_ptr_ff[top_lv]);
               count_in[top_lv]  = count_ff[top_lv] - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            count_ff[i]  <= '0;
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
         end
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   assign wr_addr = AW'(push_lv) * AW'(LEVEL_DEPTH) + AW'(wr_ptr_ff[push_lv]);
   assign rd_addr = AW'(top_lv) * AW'(LEVEL_DEPTH) + AW'(rd_ptr_ff[top_lv]);

   assign info.status        = status;
   assign info.any_waiting   = any_waiting;
   assign info.head_priority = any_waiting ? PRIO_W'(top_lv) + PRIO_W'(1) : '0;

endmodule

// ===== rtl/strict_priority_multi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_multi_fifo
// Strict priority queue: one FIFO per level, pop serves the highest level.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_func, req_priority_req and req_data_value and raise
//   start; the beat is taken at a rising edge with start high and busy low.
//   Push (func 0) stores the word at level 1..NUM_LEVELS, pop (func 1)
//   drops the head of the highest non-empty level.
//   Output: one response beat per request, shown for exactly one cycle with
//   rsp_valid high. It carries the status and the queue head after the
//   request: any_waiting, head priority and head data (zero when empty).
//   Sequence: busy stays high from the accepting edge until the response
//   has been shown, so no new request is taken before the last one is
//   answered. The store's registered read sets the steps: state update
//   and write in the accept cycle, head read in ST_READ, response in
//   ST_RESP.
//   Reset clears all occupancy and pointers; the store itself is not
//   cleared. The receiver cannot stall: each response is taken as shown.
// ----------------------------------------------------------------------------
module strict_priority_multi_fifo #(
   parameter int NUM_LEVELS  = 8,
   parameter int LEVEL_DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_func,
   input  logic [spmf_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic signed [spmf_pkg::DATA_W-1:0]   req_data_value,
   output logic                                 rsp_valid,
   output logic [spmf_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                 rsp_any_waiting,
   output logic [spmf_pkg::PRIO_W-1:0]          rsp_head_priority,
   output logic signed [spmf_pkg::DATA_W-1:0]   rsp_head_data
);

   import spmf_pkg::*;

   localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);

   state_type      state_ff;
   state_type      state_in;
   status_type     status_ff;
   logic           accept;
   logic           rd_en;
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;
   level_info_type info;

   assign accept = start && !busy;

   spmf_ctrl #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .apply        (accept),
      .func         (req_func),
      .priority_req (req_priority_req),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .rd_addr      (rd_addr),
      .info         (info)
   );

   spmf_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_LEVELS * LEVEL_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      rd_en     = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: busy = 1'b0;
         ST_READ: rd_en = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= info.status;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_any_waiting   = info.any_waiting;
   assign rsp_head_priority = info.head_priority;
   assign rsp_head_data     = info.any_waiting ? rd_data : '0;

   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("response not issued two cycles after accept");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy && $past(rd_en))
      else $error("response without preceding head read");

   a_head_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_any_waiting == (rsp_head_priority != '0)))
      else $error("head priority disagrees with any_waiting");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |-> !rsp_any_waiting)
      else $error("empty pop reported waiting entries");

endmodule

// ===== tb/sv/tb_strict_priority_multi_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strict_priority_multi_fifo
// Self-checking bench for the strict priority multi-level queue. Requests go
// in through the start/busy handshake with random gaps. A behavioral model of
// the level FIFOs predicts status and queue head for every accepted beat, and
// a monitor checks each response beat against the oldest prediction. Directed
// cases cover empty pops, bad priorities, a full level and priority order.
// Random traffic then runs randomly chosen fill, drain and mixed phases.
// ----------------------------------------------------------------------------
module tb_strict_priority_multi_fifo;
   import spmf_pkg::*;

   localparam int NUM_LEVELS  = 8;
   localparam int LEVEL_DEPTH = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      status_type          status;
      logic                any_waiting;
      logic [PRIO_W-1:0]   head_priority;
      logic [DATA_W-1:0]   head_data;
   } head_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       req_func = FUNC_PUSH;
   logic [PRIO_W-1:0]          req_priority_req = '0;
   logic signed [DATA_W-1:0]   req_data_value = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_any_waiting;
   logic [PRIO_W-1:0]          rsp_head_priority;
   logic signed [DATA_W-1:0]   rsp_head_data;

   // level FIFO model
   logic [DATA_W-1:0] lvl_words [NUM_LEVELS][LEVEL_DEPTH];
   int                lvl_fill  [NUM_LEVELS];
   int                lvl_rd    [NUM_LEVELS];
   int                lvl_wr    [NUM_LEVELS];

   head_report_type   head_report_q[$];
   int                errors = 0;
   int                cycles = 0;
   int                beats_checked = 0;
   int                status_seen [4];
   int                push_beats = 0;
   int                pop_beats = 0;

   strict_priority_multi_fifo #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_priority_req  (req_priority_req),
      .req_data_value    (req_data_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_any_waiting   (rsp_any_waiting),
      .rsp_head_priority (rsp_head_priority),
      .rsp_head_data     (rsp_head_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles, %0d responses outstanding",
                  $realtime, cycles, head_report_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int highest_level();
      for (int lv = NUM_LEVELS - 1; lv >= 0; lv--)
         if (lvl_fill[lv] != 0) return lv;
      return -1;
   endfunction

   // apply one request to the model and queue the head report it causes
   task automatic model_queue_op(input logic f, input logic [PRIO_W-1:0] p,
                                 input logic [DATA_W-1:0] d);
      head_report_type rep;
      int lv;
      rep.status = STATUS_OK;
      if (f == FUNC_PUSH) begin
         push_beats++;
         if (p == 0 || p > NUM_LEVELS) begin
            rep.status = STATUS_BAD_PRIO;
         end else begin
            lv = p - 1;
            if (lvl_fill[lv] >= LEVEL_DEPTH) begin
               rep.status = STATUS_FULL;
            end else begin
               lvl_words[lv][lvl_wr[lv]] = d;
               lvl_wr[lv] = (lvl_wr[lv] + 1) % LEVEL_DEPTH;
               lvl_fill[lv]++;
            end
         end
      end else begin
         pop_beats++;
         lv = highest_level();
         if (lv < 0) begin
            rep.status = STATUS_EMPTY;
         end else begin
            lvl_rd[lv] = (lvl_rd[lv] + 1) % LEVEL_DEPTH;
            lvl_fill[lv]--;
         end
      end
      lv = highest_level();
      if (lv < 0) begin
         rep.any_waiting   = 1'b0;
         rep.head_priority = '0;
         rep.head_data     = '0;
      end else begin
         rep.any_waiting   = 1'b1;
         rep.head_priority = PRIO_W'(lv + 1);
         rep.head_data     = lvl_words[lv][lvl_rd[lv]];
      end
      status_seen[rep.status]++;
      head_report_q.push_back(rep);
   endtask

   task automatic send_beat(input logic f, input logic [PRIO_W-1:0] p,
                            input logic [DATA_W-1:0] d, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= f;
      req_priority_req <= p;
      req_data_value   <= d;
      do @(posedge clock); while (busy);
      model_queue_op(f, p, d);
   endtask

   always @(posedge clock) begin
      head_report_type exp_rep;
      if (!reset && $isunknown(rsp_valid)) begin
         $display("%0t rsp_valid unknown", $realtime);
         errors++;
      end else if (!reset && rsp_valid) begin
         if (head_report_q.size() == 0) begin
            $display("%0t unexpected response beat: status %0d prio %0d data %h",
                     $realtime, rsp_status, rsp_head_priority, rsp_head_data);
            errors++;
         end else begin
            exp_rep = head_report_q.pop_front();
            beats_checked++;
            if (rsp_status !== exp_rep.status) begin
               $display("%0t status: expected %0d actual %0d",
                        $realtime, exp_rep.status, rsp_status);
               errors++;
            end
            if (rsp_any_waiting !== exp_rep.any_waiting) begin
               $display("%0t any_waiting: expected %b actual %b",
                        $realtime, exp_rep.any_waiting, rsp_any_waiting);
               errors++;
            end
            if (rsp_head_priority !== exp_rep.head_priority) begin
               $display("%0t head_priority: expected %0d actual %0d",
                        $realtime, exp_rep.head_priority, rsp_head_priority);
               errors++;
            end
            if (rsp_head_data !== exp_rep.head_data) begin
               $display("%0t head_data: expected %h actual %h",
                        $realtime, exp_rep.head_data, rsp_head_data);
               errors++;
            end
         end
      end
   end

   // pop with nothing queued, then pushes at illegal priorities
   task automatic test_empty_and_invalid();
      send_beat(FUNC_POP, 4'd3, 32'h1234_5678, 0);
      send_beat(FUNC_PUSH, 4'd0, 32'h7fff_ffff, 0);
      send_beat(FUNC_PUSH, 4'(NUM_LEVELS + 1), 32'h8000_0000, 2);
      send_beat(FUNC_PUSH, 4'd15, 32'hffff_ffff, 0);
   endtask

   // fill level 1 to the brim, then one more push
   task automatic test_level_full();
      logic [DATA_W-1:0] extremes [4];
      extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
      for (int i = 0; i < LEVEL_DEPTH; i++)
         send_beat(FUNC_PUSH, 4'd1, (i < 4) ? extremes[i] : $urandom,
                   (i % 5 == 0) ? $urandom_range(0, 16) : 0);
      send_beat(FUNC_PUSH, 4'd1, 32'hdead_beef, 0);
   endtask

   // top level overtakes, pop ignores its operands
   task automatic test_priority_order();
      send_beat(FUNC_PUSH, 4'(NUM_LEVELS), 32'h5a5a_a5a5, 1);
      send_beat(FUNC_POP, 4'd15, 32'hffff_ffff, 0);
      send_beat(FUNC_POP, 4'd0, 32'h0000_0000, 3);
   endtask

   task automatic test_random_traffic(input int n_items);
      int                done;
      int                pct_push;
      int                hot;
      int                gap;
      bit                burst;
      logic              f;
      logic [PRIO_W-1:0] p;
      logic [DATA_W-1:0] d;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(0, 2))
            0: pct_push = 85;
            1: pct_push = 15;
            default: pct_push = 50;
         endcase
         hot   = $urandom_range(1, NUM_LEVELS);
         burst = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(20, 60)) begin
            f = ($urandom_range(0, 99) < pct_push) ? FUNC_PUSH : FUNC_POP;
            case ($urandom_range(0, 9))
               0: p = PRIO_W'($urandom_range(0, 15));
               1, 2, 3, 4: p = PRIO_W'(hot);
               default: p = PRIO_W'($urandom_range(1, NUM_LEVELS));
            endcase
            d   = $urandom;
            gap = burst ? 0 : $urandom_range(0, 16);
            send_beat(f, p, d, gap);
            if (!(f == FUNC_PUSH && (p == 0 || p > NUM_LEVELS))) done++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
         lvl_fill[i] = 0;
         lvl_rd[i]   = 0;
         lvl_wr[i]   = 0;
      end
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_and_invalid();
      test_level_full();
      test_priority_order();
      test_random_traffic(900);

      start <= 1'b0;
      while (head_report_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (head_report_q.size() != 0) begin
         $display("%0t %0d responses never arrived", $realtime, head_report_q.size());
         errors++;
      end

      $display("Checked %0d response beats: %0d pushes, %0d pops.",
               beats_checked, push_beats, pop_beats);
      $display("Status mix: ok %0d, bad priority %0d, level full %0d, empty pop %0d.",
               status_seen[STATUS_OK], status_seen[STATUS_BAD_PRIO],
               status_seen[STATUS_FULL], status_seen[STATUS_EMPTY]);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
